>>> rtl/time_of_day_clock_seven_segment_defines.svh
// ----------------------------------------------------------------------------
// time-of-day clock assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef TIME_OF_DAY_CLOCK_SEVEN_SEGMENT_DEFINES_SVH
`define TIME_OF_DAY_CLOCK_SEVEN_SEGMENT_DEFINES_SVH

// same-cycle implication
`define TODC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("todc assertion failed");

// next-cycle implication
`define TODC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("todc assertion failed");

`endif

>>> rtl/todc_pkg.sv
// ----------------------------------------------------------------------------
// todc_pkg
// types, constants and helpers of the time-of-day clock
// ----------------------------------------------------------------------------
package todc_pkg;

	localparam int DIGIT_COUNT_DEF = 8;
	localparam int QUEUE_DEPTH     = 2;
	localparam int CODE_W          = 4;

	localparam logic [15:0] TPS_RST    = 16'd1000;
	localparam logic [4:0]  PHOUR_RST  = 5'd22;
	localparam logic [5:0]  PMIN_RST   = 6'd59;
	localparam logic [5:0]  PSEC_RST   = 6'd58;
	localparam logic [4:0]  HOUR_RST   = 5'd23;
	localparam logic [5:0]  MIN_RST    = 6'd59;
	localparam logic [5:0]  SEC_RST    = 6'd57;
	localparam logic [3:0]  DASH_CODE  = 4'd10;

	typedef enum logic [1:0] {
		REG_TPS  = 2'd0,
		REG_HOUR = 2'd1,
		REG_MIN  = 2'd2,
		REG_SEC  = 2'd3
	} todc_reg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} todc_q_stat_t;

	typedef struct packed {
		logic [3:0] tens;
		logic [3:0] ones;
	} todc_bcd_t;

	// split a value below 64 into decimal digits
	function automatic todc_bcd_t to_bcd(input logic [5:0] v);
		todc_bcd_t r;
		logic [5:0] rem;
		r   = '0;
		rem = v;
		priority if (v >= 6'd60) begin
			r.tens = 4'd6;
			rem    = v - 6'd60;
		end else if (v >= 6'd50) begin
			r.tens = 4'd5;
			rem    = v - 6'd50;
		end else if (v >= 6'd40) begin
			r.tens = 4'd4;
			rem    = v - 6'd40;
		end else if (v >= 6'd30) begin
			r.tens = 4'd3;
			rem    = v - 6'd30;
		end else if (v >= 6'd20) begin
			r.tens = 4'd2;
			rem    = v - 6'd20;
		end else if (v >= 6'd10) begin
			r.tens = 4'd1;
			rem    = v - 6'd10;
		end else begin
			r.tens = 4'd0;
		end
		r.ones = rem[3:0];
		return r;
	endfunction

	// common-anode segment decode, active low
	function automatic logic [7:0] seg_decode(input logic [3:0] code);
		logic [7:0] p;
		unique case (code)
			4'd0:    p = 8'hc0;
			4'd1:    p = 8'hf9;
			4'd2:    p = 8'ha4;
			4'd3:    p = 8'hb0;
			4'd4:    p = 8'h99;
			4'd5:    p = 8'h92;
			4'd6:    p = 8'h82;
			4'd7:    p = 8'hf8;
			4'd8:    p = 8'h80;
			4'd9:    p = 8'h90;
			4'd10:   p = 8'hbf;
			default: p = 8'hff;
		endcase
		return p;
	endfunction

endpackage

>>> rtl/todc_front.sv
// ----------------------------------------------------------------------------
// todc_front
// tick counter, time keeping, preset load and digit cache; hands the
// pre-tick cache snapshot to the scan queue
// ----------------------------------------------------------------------------
module todc_front import todc_pkg::*; #(
	parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [15:0]                   cfg_data,
	input  logic                          push,
	output logic                          full,
	input  logic                          preset_key,
	input  todc_q_stat_t                  q_stat,
	output logic                          q_push,
	output logic [DIGIT_COUNT*CODE_W-1:0] q_data
);

	logic [15:0] tps_q;
	logic [4:0]  phour_q;
	logic [5:0]  pmin_q;
	logic [5:0]  psec_q;

	logic [15:0] tick_q;
	logic [4:0]  hour_q;
	logic [5:0]  min_q;
	logic [5:0]  sec_q;
	logic [DIGIT_COUNT-1:0][CODE_W-1:0] cache_q;

	logic        accept;
	logic [16:0] tick_nxt;
	logic        sec_done;
	logic [4:0]  h_base, h_inc, h_new;
	logic [5:0]  m_base, m_inc, m_new;
	logic [5:0]  s_base, s_inc, s_new;
	todc_bcd_t   h_bcd, m_bcd, s_bcd;

	assign full   = q_stat.full;
	assign accept = push && !q_stat.full;
	assign q_push = accept;
	assign q_data = cache_q;

	always_comb begin
		tick_nxt = {1'b0, tick_q} + 17'd1;
		sec_done = tick_nxt >= {1'b0, tps_q};

		h_base = preset_key ? phour_q : hour_q;
		m_base = preset_key ? pmin_q  : min_q;
		s_base = preset_key ? psec_q  : sec_q;

		s_inc = s_base + 6'd1;
		m_inc = m_base + 6'd1;
		h_inc = h_base + 5'd1;
		h_new = h_base;
		m_new = m_base;
		s_new = s_inc;
		if (s_inc >= 6'd60) begin
			s_new = '0;
			m_new = m_inc;
			if (m_inc >= 6'd60) begin
				m_new = '0;
				h_new = (h_inc >= 5'd24) ? 5'd0 : h_inc;
			end
		end

		h_bcd = to_bcd({1'b0, h_new});
		m_bcd = to_bcd(m_new);
		s_bcd = to_bcd(s_new);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q   <= TPS_RST;
			phour_q <= PHOUR_RST;
			pmin_q  <= PMIN_RST;
			psec_q  <= PSEC_RST;
		end else if (cfg_we) begin
			unique case (todc_reg_t'(cfg_index))
				REG_TPS:  tps_q   <= cfg_data;
				REG_HOUR: phour_q <= cfg_data[4:0];
				REG_MIN:  pmin_q  <= cfg_data[5:0];
				REG_SEC:  psec_q  <= cfg_data[5:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			hour_q  <= HOUR_RST;
			min_q   <= MIN_RST;
			sec_q   <= SEC_RST;
			cache_q <= '0;
		end else if (accept) begin
			tick_q <= sec_done ? 16'd0 : tick_nxt[15:0];
			if (sec_done) begin
				hour_q     <= h_new;
				min_q      <= m_new;
				sec_q      <= s_new;
				cache_q[0] <= h_bcd.tens;
				cache_q[1] <= h_bcd.ones;
				cache_q[2] <= DASH_CODE;
				cache_q[3] <= m_bcd.tens;
				cache_q[4] <= m_bcd.ones;
				cache_q[5] <= DASH_CODE;
				cache_q[6] <= s_bcd.tens;
				cache_q[7] <= s_bcd.ones;
			end else begin
				hour_q <= h_base;
				min_q  <= m_base;
				sec_q  <= s_base;
			end
		end
	end

endmodule

>>> rtl/todc_queue.sv
// ----------------------------------------------------------------------------
// todc_queue
// short fifo of cache snapshots between front and scan
// ----------------------------------------------------------------------------
module todc_queue import todc_pkg::*; #(
	parameter int WIDTH = DIGIT_COUNT_DEF * CODE_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output todc_q_stat_t     stat
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [PW:0]      cnt_q;

	assign stat.full  = cnt_q == (PW+1)'(QUEUE_DEPTH);
	assign stat.empty = cnt_q == '0;
	assign rdata      = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			unique case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> rtl/todc_scan.sv
// ----------------------------------------------------------------------------
// todc_scan
// walks one snapshot digit by digit into the result register
// ----------------------------------------------------------------------------
module todc_scan import todc_pkg::*; #(
	parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  todc_q_stat_t                  q_stat,
	input  logic [DIGIT_COUNT*CODE_W-1:0] q_data,
	output logic                          q_pop,
	input  logic                          pop,
	output logic                          empty,
	output logic [2:0]                    digit_position,
	output logic [7:0]                    segment_pattern,
	output logic                          last_digit
);

	localparam int IW = $clog2(DIGIT_COUNT);

	logic [IW-1:0] idx_q;
	logic          ovalid_q;
	logic [2:0]    pos_q;
	logic [7:0]    pat_q;
	logic          last_q;
	logic          load;
	logic          is_last;
	logic [CODE_W-1:0] code;

	assign load    = !q_stat.empty && (!ovalid_q || pop);
	assign is_last = idx_q == IW'(DIGIT_COUNT - 1);
	assign q_pop   = load && is_last;
	assign code    = q_data[idx_q*CODE_W +: CODE_W];

	assign empty           = !ovalid_q;
	assign digit_position  = pos_q;
	assign segment_pattern = pat_q;
	assign last_digit      = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= is_last ? '0 : idx_q + 1'b1;
			end
			if (load) begin
				ovalid_q <= 1'b1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (load) begin
			pos_q  <= 3'(idx_q);
			pat_q  <= seg_decode(code);
			last_q <= is_last;
		end
	end

endmodule

>>> rtl/time_of_day_clock_seven_segment.sv
// ----------------------------------------------------------------------------
// time_of_day_clock_seven_segment
// hh:mm:ss clock with an eight-digit multiplexed seven-segment scan
// ----------------------------------------------------------------------------
// Input channel: one beat per timer tick, push/full, payload preset_key.
// The tick counts toward a second, loads the preset time when preset_key
// is set, and queues a snapshot of the digit cache as it stood before the
// tick. On a completed second the time advances and the cache is rewritten
// as HH-MM-SS, so the new time shows on the scan of the next tick.
// Result channel: empty/pop, eight beats per tick, digit 0 first, with
// last_digit set on digit 7.
// Snapshots are registered in the queue, digits in the scan register.
// Throughput: one result a cycle from the scan register while pop is not
// stalled and the queue holds a snapshot; the front takes ticks while the
// two-entry snapshot queue has room.
// Configuration: cfg_we/cfg_index/cfg_data, taken in the cycle of the write.
// Reset: time 23:59:57, tick count zero, cache all zero digits, queue and
// result register empty, registers at their defaults.
// A stalled pop holds the current result; the front keeps taking ticks
// until the queue fills, then raises full.
// ----------------------------------------------------------------------------
module time_of_day_clock_seven_segment import todc_pkg::*; #(
	parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic        preset_key,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  digit_position,
	output logic [7:0]  segment_pattern,
	output logic        last_digit
);

	localparam int SNAP_W = DIGIT_COUNT * CODE_W;

	todc_q_stat_t      q_stat;
	logic              q_push;
	logic              q_pop;
	logic [SNAP_W-1:0] q_wdata;
	logic [SNAP_W-1:0] q_rdata;

	todc_front #(.DIGIT_COUNT(DIGIT_COUNT)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.full       (full),
		.preset_key (preset_key),
		.q_stat     (q_stat),
		.q_push     (q_push),
		.q_data     (q_wdata)
	);

	todc_queue #(.WIDTH(SNAP_W)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wdata  (q_wdata),
		.rd     (q_pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	todc_scan #(.DIGIT_COUNT(DIGIT_COUNT)) u_scan (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_stat          (q_stat),
		.q_data          (q_rdata),
		.q_pop           (q_pop),
		.pop             (pop),
		.empty           (empty),
		.digit_position  (digit_position),
		.segment_pattern (segment_pattern),
		.last_digit      (last_digit)
	);

endmodule

>>> rtl/todc_checker.sv
// ----------------------------------------------------------------------------
// todc_checker
// port-level checks of the result channel, bound to the top level
// ----------------------------------------------------------------------------
`include "time_of_day_clock_seven_segment_defines.svh"

module todc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [2:0] digit_position,
	input logic [7:0] segment_pattern,
	input logic       last_digit
);

	logic        last_ok;
	logic        stall;
	logic [10:0] beat;
	logic        took_mid;
	logic [2:0]  next_pos;
	logic        pat_ok;

	assign last_ok  = last_digit == (digit_position == 3'd7);
	assign stall    = !empty && !pop;
	assign beat     = {digit_position, segment_pattern};
	assign took_mid = pop && !empty && !last_digit;
	assign next_pos = digit_position + 3'd1;
	assign pat_ok   = segment_pattern == 8'hc0 || segment_pattern == 8'hf9 ||
		segment_pattern == 8'ha4 || segment_pattern == 8'hb0 ||
		segment_pattern == 8'h99 || segment_pattern == 8'h92 ||
		segment_pattern == 8'h82 || segment_pattern == 8'hf8 ||
		segment_pattern == 8'h80 || segment_pattern == 8'h90 ||
		segment_pattern == 8'hbf;

	// last flag marks digit 7 only
	`TODC_ASSERT_IMP(a_last_pos, clk, arst_n, !empty, last_ok)

	// stalled result beat holds
	`TODC_ASSERT_NXT(a_hold, clk, arst_n, stall, !empty && $stable(beat))

	// scan order within a tick
	`TODC_ASSERT_IMP(a_order, clk, arst_n, $past(took_mid) && !empty, digit_position == $past(next_pos))

	// only digit or dash patterns
	`TODC_ASSERT_IMP(a_pattern, clk, arst_n, !empty, pat_ok)

endmodule

bind time_of_day_clock_seven_segment todc_checker u_todc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.empty           (empty),
	.pop             (pop),
	.digit_position  (digit_position),
	.segment_pattern (segment_pattern),
	.last_digit      (last_digit)
);
